/* rtl/core/nsd_pkg.sv */
`timescale 1ns / 1ps
// nsd_pkg: shared types and constants for the nearest symbol detector.
// Used by nsd_dist, nearest_symbol_detector and nsd_checker; no dependencies.
package nsd_pkg;

  // Default sizing of the point store and sample width
  localparam int MAX_POINTS_DEF   = 4096;
  localparam int SAMPLE_WIDTH_DEF = 16;

  // Fixed field widths
  localparam int INDEX_W   = 12;  // point_index / detected_index
  localparam int SIZE_W    = 13;  // points_in_use register
  localparam int THR_W     = 34;  // early_exit_threshold register
  localparam int CFG_IDX_W = 4;   // configuration register index

  // Item function codes
  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_DETECT = 1'b1;

  // Configuration register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POINTS_IN_USE = 4'd0,
    REG_THRESHOLD     = 4'd1
  } cfg_reg_t;

  // Control states
  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } nsd_state_t;

endpackage

/* rtl/core/nsd_dist.sv */
`timescale 1ns / 1ps
// nsd_dist: two-stage squared Euclidean distance between a sample and a point.
// Stage 1 squares the absolute I/Q differences, stage 2 adds them. Uses nsd_pkg.
module nsd_dist import nsd_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  localparam int DW = 2 * SAMPLE_WIDTH + 2
) (
  input  logic                           clk,
  input  logic signed [SAMPLE_WIDTH-1:0] ref_i,
  input  logic signed [SAMPLE_WIDTH-1:0] ref_q,
  input  logic signed [SAMPLE_WIDTH-1:0] pt_i,
  input  logic signed [SAMPLE_WIDTH-1:0] pt_q,
  output logic        [DW-1:0]           dist_sq
);

  localparam int EW = SAMPLE_WIDTH + 1;

  logic signed [EW-1:0] diff_i;
  logic signed [EW-1:0] diff_q;
  logic        [EW-1:0] mag_i;
  logic        [EW-1:0] mag_q;
  logic        [DW-1:0] sq_i;
  logic        [DW-1:0] sq_q;

  // Exact differences and their magnitudes (|d| <= 2^SAMPLE_WIDTH fits EW bits)
  always_comb begin
    diff_i = EW'(ref_i) - EW'(pt_i);
    diff_q = EW'(ref_q) - EW'(pt_q);
    mag_i  = diff_i[EW-1] ? EW'(-diff_i) : EW'(diff_i);
    mag_q  = diff_q[EW-1] ? EW'(-diff_q) : EW'(diff_q);
  end

  // Stage 1: squares
  always_ff @(posedge clk) begin
    sq_i <= DW'(mag_i) * DW'(mag_i);
    sq_q <= DW'(mag_q) * DW'(mag_q);
  end

  // Stage 2: sum, cannot overflow DW bits
  always_ff @(posedge clk) begin
    dist_sq <= sq_i + sq_q;
  end

endmodule

/* rtl/core/nearest_symbol_detector.sv */
`timescale 1ns / 1ps
// nearest_symbol_detector: top level, point store, scan control and result register.
// Depends on nsd_pkg and nsd_dist.
//
// Usage
//   Item channel: an item is taken at a rising edge with start high and busy low.
//   func = load writes {sample_i, sample_q} to store entry point_index in that
//   same edge; busy stays low and no result follows. func = detect starts a
//   scan; busy is high until the result is shown.
//   Result: detected_index is valid for one cycle while done is high. The
//   receiver cannot stall, so nothing is held back.
//   Config channel: cfg_ready is always high; write only while busy is low.
//   Index 0 is points_in_use, index 1 early_exit_threshold; others are dropped.
// Timing
//   The scan reads one stored point per cycle from a single-port store with a
//   registered read, then a two-stage distance pipeline and a compare stage.
//   A detect that ends on point k (early exit or last point) raises done
//   once point k has passed the store read, the two distance stages and
//   the compare stage; done is registered. A new item is taken in the
//   cycle done is high.
// Reset
//   rst clears control state and restores points_in_use = 4 and a zero
//   threshold. The store is not cleared; detect only over written entries.
module nearest_symbol_detector import nsd_pkg::*; #(
  parameter int MAX_POINTS   = MAX_POINTS_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // item channel
  input  logic                           start,
  output logic                           busy,
  input  logic                           func,
  input  logic        [INDEX_W-1:0]      point_index,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_q,
  // result
  output logic                           done,
  output logic        [INDEX_W-1:0]      detected_index,
  // configuration channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic        [CFG_IDX_W-1:0]    cfg_index,
  input  logic        [THR_W-1:0]        cfg_data
);

  localparam int AW   = $clog2(MAX_POINTS);
  localparam int SW   = SAMPLE_WIDTH;
  localparam int DW   = 2 * SW + 2;
  localparam int CMPW = (DW > THR_W) ? DW : THR_W;
  localparam int CW   = $clog2(MAX_POINTS + 1);
  localparam int PW   = (CW > SIZE_W) ? CW : SIZE_W;
  localparam int LW   = (AW + 1 > INDEX_W) ? AW + 1 : INDEX_W;

  // Configuration registers
  logic [SIZE_W-1:0] points_in_use;
  logic [THR_W-1:0]  early_exit_threshold;

  // Control
  nsd_state_t state, state_next;
  logic          item_acc;
  logic          load_acc;
  logic          detect_acc;
  logic [AW-1:0] last_idx;
  logic [AW-1:0] last_idx_next;
  logic [AW-1:0] rd_addr;
  logic          issue_done;
  logic          issue_en;
  logic          finish;
  logic [AW-1:0] finish_idx;

  // Scan pipeline tags: store read, squares, distance
  logic          v1, v2, v3;
  logic [AW-1:0] idx1, idx2, idx3;

  // Received sample held for the scan
  logic signed [SW-1:0] ref_i;
  logic signed [SW-1:0] ref_q;

  // Point store
  logic [2*SW-1:0] store_mem [MAX_POINTS];
  logic [2*SW-1:0] rd_data;
  logic            wr_en;

  // Distance and best-so-far
  logic [DW-1:0] dist_sq;
  logic [DW-1:0] best_d;
  logic [AW-1:0] best_idx;
  logic          is_first;
  logic          hit;
  logic          better;
  logic          is_last;

  assign busy       = (state != ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign item_acc   = start && !busy;
  assign load_acc   = item_acc && (func == FUNC_LOAD);
  assign detect_acc = item_acc && (func == FUNC_DETECT);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      points_in_use        <= SIZE_W'(4);
      early_exit_threshold <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_POINTS_IN_USE: points_in_use        <= cfg_data[SIZE_W-1:0];
        REG_THRESHOLD:     early_exit_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // Last point to scan: size clipped to the store, at least point 0
  always_comb begin
    logic [PW-1:0] size_ext;
    logic [CW-1:0] size;
    size_ext = PW'(points_in_use);
    if (size_ext > PW'(MAX_POINTS)) begin
      size = CW'(MAX_POINTS);
    end else begin
      size = CW'(size_ext);
    end
    if (size == '0) begin
      last_idx_next = '0;
    end else begin
      last_idx_next = AW'(size - CW'(1));
    end
  end

  // Store: write on load, registered read during the scan
  assign wr_en = load_acc && (LW'(point_index) < LW'(MAX_POINTS));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[AW'(point_index)] <= {sample_i, sample_q};
    end
  end

  always_ff @(posedge clk) begin
    if (issue_en) begin
      rd_data <= store_mem[rd_addr];
    end
  end

  // Distance pipeline
  nsd_dist #(
    .SAMPLE_WIDTH (SW)
  ) u_dist (
    .clk     (clk),
    .ref_i   (ref_i),
    .ref_q   (ref_q),
    .pt_i    (rd_data[2*SW-1:SW]),
    .pt_q    (rd_data[SW-1:0]),
    .dist_sq (dist_sq)
  );

  // Decision on the distance of point idx3
  always_comb begin
    is_first   = (idx3 == '0);
    hit        = !is_first && (CMPW'(dist_sq) < CMPW'(early_exit_threshold));
    better     = is_first || (dist_sq < best_d);
    is_last    = (idx3 == last_idx);
    finish     = v3 && (hit || is_last);
    finish_idx = (hit || better) ? idx3 : best_idx;
  end

  // State machine
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    issue_en   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (detect_acc) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        issue_en = !issue_done && !finish;
        if (finish) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Read address sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_addr    <= '0;
      issue_done <= 1'b1;
    end else if (detect_acc) begin
      rd_addr    <= '0;
      issue_done <= 1'b0;
    end else if (issue_en) begin
      if (rd_addr == last_idx) begin
        issue_done <= 1'b1;
      end else begin
        rd_addr <= rd_addr + AW'(1);
      end
    end
  end

  // Pipeline valid tags, flushed when the scan ends
  always_ff @(posedge clk) begin
    if (rst || finish) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= issue_en;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    idx1 <= rd_addr;
    idx2 <= idx1;
    idx3 <= idx2;
    if (detect_acc) begin
      ref_i    <= sample_i;
      ref_q    <= sample_q;
      last_idx <= last_idx_next;
    end
    if (v3 && !hit && better) begin
      best_d   <= dist_sq;
      best_idx <= idx3;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= finish;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      detected_index <= INDEX_W'(finish_idx);
    end
  end

endmodule

/* rtl/core/nsd_checker.sv */
`timescale 1ns / 1ps
// nsd_checker: port-level checks on item, result and busy timing of the detector.
// Uses nsd_pkg; bound to nearest_symbol_detector at the end of this file.
module nsd_checker import nsd_pkg::*; (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic func,
  input logic done
);

  // A result only follows a scan in progress
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a scan in progress");

  // One result per detect: never two in a row
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result shown on two consecutive cycles");

  // A scan ends only with its result
  a_end_with_result: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $fell(busy)) |-> done)
    else $error("scan ended without a result");

  // A load item never occupies the block
  a_load_no_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (func == FUNC_LOAD)) |=> !busy)
    else $error("load item raised busy");

  // A detect item always starts a scan
  a_detect_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (func == FUNC_DETECT)) |=> busy)
    else $error("detect item did not start a scan");

endmodule

bind nearest_symbol_detector nsd_checker u_nsd_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .func  (func),
  .done  (done)
);

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// tb_top: self-checking bench for nearest_symbol_detector (load and detect items).
// Depends on nsd_pkg and the detector RTL; a small scoreboard predicts every detection.
module tb_top;
  import nsd_pkg::*;

  localparam int unsigned STALL_LIMIT = 20000;  // longer than a full 4096-point scan
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 4'hF;
  localparam logic [THR_W-1:0] THR_MAX = '1;

  typedef struct packed {
    logic                               func;
    logic        [INDEX_W-1:0]          point_index;
    logic signed [SAMPLE_WIDTH_DEF-1:0] sample_i;
    logic signed [SAMPLE_WIDTH_DEF-1:0] sample_q;
  } symbol_item_t;

  // Scoreboard: own copy of the point store and registers, queue of expected indices
  class symbol_scoreboard;
    logic signed [SAMPLE_WIDTH_DEF-1:0] pt_i [MAX_POINTS_DEF];
    logic signed [SAMPLE_WIDTH_DEF-1:0] pt_q [MAX_POINTS_DEF];
    logic [SIZE_W-1:0] size_reg;
    logic [THR_W-1:0] thr_reg;
    logic [INDEX_W-1:0] expected_indices[$];
    int unsigned errors;

    function new();
      size_reg = 13'd4;
      thr_reg = '0;
      errors = 0;
      foreach (pt_i[k]) begin
        pt_i[k] = '0;
        pt_q[k] = '0;
      end
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [THR_W-1:0] data);
      case (idx)
        REG_POINTS_IN_USE: size_reg = data[SIZE_W-1:0];
        REG_THRESHOLD: thr_reg = data;
        default: ;
      endcase
    endfunction

    function longint unsigned sq_distance(logic signed [SAMPLE_WIDTH_DEF-1:0] si,
                                          logic signed [SAMPLE_WIDTH_DEF-1:0] sq,
                                          int unsigned k);
      longint di;
      longint dq;
      di = longint'(si) - longint'(pt_i[k]);
      dq = longint'(sq) - longint'(pt_q[k]);
      return di * di + dq * dq;
    endfunction

    // Scan from point 0; first distance after point 0 under the threshold wins, else strict minimum
    function logic [INDEX_W-1:0] nearest_index(logic signed [SAMPLE_WIDTH_DEF-1:0] si,
                                               logic signed [SAMPLE_WIDTH_DEF-1:0] sq);
      int unsigned span;
      int unsigned best;
      longint unsigned best_d;
      longint unsigned d;
      span = (size_reg > MAX_POINTS_DEF) ? MAX_POINTS_DEF : size_reg;
      best = 0;
      best_d = sq_distance(si, sq, 0);
      for (int unsigned k = 1; k < span; k++) begin
        d = sq_distance(si, sq, k);
        if (d < thr_reg) begin
          best = k;
          break;
        end
        if (d < best_d) begin
          best = k;
          best_d = d;
        end
      end
      return best[INDEX_W-1:0];
    endfunction

    function void note_item(symbol_item_t it);
      if (it.func == FUNC_LOAD) begin
        pt_i[it.point_index] = it.sample_i;
        pt_q[it.point_index] = it.sample_q;
      end else begin
        expected_indices.push_back(nearest_index(it.sample_i, it.sample_q));
      end
    endfunction

    function void check_result(logic [INDEX_W-1:0] got);
      logic [INDEX_W-1:0] want;
      if (expected_indices.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual detected_index %0d", $time, got);
        errors++;
        return;
      end
      want = expected_indices.pop_front();
      if (got !== want) begin
        $display("%0t: detected_index mismatch: expected %0d, actual %0d", $time, want, got);
        errors++;
      end
    endfunction

    function int pending();
      return expected_indices.size();
    endfunction

    function void report_leftover();
      if (expected_indices.size() != 0) begin
        $display("%0t: %0d results missing: expected detected_index %0d first, actual none",
                 $time, expected_indices.size(), expected_indices[0]);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic func;
  logic [INDEX_W-1:0] point_index;
  logic signed [SAMPLE_WIDTH_DEF-1:0] sample_i;
  logic signed [SAMPLE_WIDTH_DEF-1:0] sample_q;
  logic done;
  logic [INDEX_W-1:0] detected_index;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [THR_W-1:0] cfg_data;

  symbol_scoreboard sb;
  int unsigned idle_cycles = 0;
  bit no_gaps;
  bit written [MAX_POINTS_DEF];
  int unsigned span;  // entries the current size setting reads

  nearest_symbol_detector DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .func(func),
    .point_index(point_index),
    .sample_i(sample_i),
    .sample_q(sample_q),
    .done(done),
    .detected_index(detected_index),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Monitor: items taken, results shown and register writes, all on pre-edge values
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (start && !busy) sb.note_item(symbol_item_t'({func, point_index, sample_i, sample_q}));
      if (done) sb.check_result(detected_index);
      if (cfg_valid && cfg_ready) sb.set_register(cfg_index, cfg_data);
      if ((start && !busy) || done || (cfg_valid && cfg_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // Watchdog on a stalled handshake
  initial begin
    wait (idle_cycles >= STALL_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Extremes, full-range noise and a coarse grid that gives ties
  function automatic logic signed [SAMPLE_WIDTH_DEF-1:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2, 3, 4, 5: return 16'($urandom);
      6: return -16'sd24576;
      7: return -16'sd8192;
      8: return 16'sd8192;
      default: return 16'sd24576;
    endcase
  endfunction

  function automatic logic [THR_W-1:0] pick_threshold();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return THR_MAX;
      2: return 34'd1;
      3: return 34'($urandom_range(0, 1 << 28));
      default: return {2'($urandom), 32'($urandom)};
    endcase
  endfunction

  // Sizes stay small so that filling the store costs few items
  function automatic int unsigned pick_size();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 7) return $urandom_range(2, 16);
    if (r < 9) return $urandom_range(17, 32);
    return 2;
  endfunction

  // One item on the command port; returns at the edge that takes it
  task automatic drive_item(logic f, logic [INDEX_W-1:0] idx,
                            logic signed [SAMPLE_WIDTH_DEF-1:0] si,
                            logic signed [SAMPLE_WIDTH_DEF-1:0] sq);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    func <= f;
    point_index <= idx;
    sample_i <= si;
    sample_q <= sq;
    do @(posedge clk); while (busy);
  endtask

  task automatic load_point(logic [INDEX_W-1:0] idx, logic signed [SAMPLE_WIDTH_DEF-1:0] si,
                            logic signed [SAMPLE_WIDTH_DEF-1:0] sq);
    written[idx] = 1'b1;
    drive_item(FUNC_LOAD, idx, si, sq);
  endtask

  // point_index is ignored on detect, so it carries noise
  task automatic send_detect(logic signed [SAMPLE_WIDTH_DEF-1:0] si,
                             logic signed [SAMPLE_WIDTH_DEF-1:0] sq);
    drive_item(FUNC_DETECT, INDEX_W'($urandom), si, sq);
  endtask

  // Every entry a detect can read must hold a point first
  task automatic fill_points(int unsigned upto);
    for (int unsigned k = 0; k < upto; k++)
      if (!written[k]) load_point(k[INDEX_W-1:0], pick_coord(), pick_coord());
  endtask

  // Sample on a stored point, close to one, or anywhere
  task automatic detect_near();
    int unsigned k;
    int unsigned spread;
    logic signed [SAMPLE_WIDTH_DEF-1:0] si;
    logic signed [SAMPLE_WIDTH_DEF-1:0] sq;
    k = $urandom_range(0, span - 1);
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        si = sb.pt_i[k];
        sq = sb.pt_q[k];
      end
      3, 4, 5: begin
        spread = $urandom_range(0, 1) ? 2 : 512;
        si = sb.pt_i[k] + 16'($urandom_range(0, 2 * spread) - spread);
        sq = sb.pt_q[k] + 16'($urandom_range(0, 2 * spread) - spread);
      end
      default: begin
        si = pick_coord();
        sq = pick_coord();
      end
    endcase
    send_detect(si, sq);
  endtask

  task automatic random_item();
    logic [INDEX_W-1:0] idx;
    if ($urandom_range(0, 99) < 40) begin
      idx = ($urandom_range(0, 9) < 8) ? INDEX_W'($urandom_range(0, span - 1))
                                        : INDEX_W'($urandom);
      load_point(idx, pick_coord(), pick_coord());
    end else begin
      detect_near();
    end
  endtask

  // Drop start, let every expected result come, then allow the pipeline to drain
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0 || busy) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [THR_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Size goes out with noise above bit 12 half the time; only the low 13 bits count
  task automatic set_config(int unsigned size, logic [THR_W-1:0] thr);
    logic [THR_W-1:0] size_word;
    wait_idle();
    size_word = '0;
    size_word[SIZE_W-1:0] = size[SIZE_W-1:0];
    if ($urandom_range(0, 1)) size_word[THR_W-1:SIZE_W] = 21'($urandom);
    write_reg(REG_POINTS_IN_USE, size_word);
    write_reg(REG_THRESHOLD, thr);
    span = (size > MAX_POINTS_DEF) ? MAX_POINTS_DEF : ((size < 1) ? 1 : size);
    fill_points(span);
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    start = 1'b0;
    func = FUNC_LOAD;
    point_index = '0;
    sample_i = '0;
    sample_q = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_POINTS_IN_USE;
    cfg_data = '0;
    no_gaps = 1'b0;
    span = 4;
    foreach (written[k]) written[k] = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset setting: four points at the corners, zero threshold
    load_point(12'd0, 16'sh8000, 16'sh8000);
    load_point(12'd1, 16'sh7FFF, 16'sh7FFF);
    load_point(12'd2, 16'sh8000, 16'sh7FFF);
    load_point(12'd3, 16'sh7FFF, 16'sh8000);
    send_detect(16'sh7FFF, 16'sh7FFF);
    send_detect(16'sh8000, 16'sh8000);
    send_detect(16'sh0000, 16'sh0000);
    send_detect(16'sh8000, 16'sh7FFF);
    send_detect(16'sh7FFF, 16'sh8000);

    // Duplicate point: the tie keeps the earlier index
    load_point(12'd3, 16'sh7FFF, 16'sh7FFF);
    send_detect(16'sh7D00, 16'sh7D00);

    // Two points, top threshold: every scan stops at point 1
    set_config(2, THR_MAX);
    send_detect(16'sh0000, 16'sh0000);
    send_detect(16'sh8000, 16'sh8000);

    // Sizes 0 and 1 only look at point 0
    set_config(0, 34'd0);
    send_detect(16'sh7FFF, 16'sh7FFF);
    set_config(1, 34'd1);
    send_detect(16'sh1234, -16'sd4321);

    // Unmapped register index: nothing changes
    wait_idle();
    write_reg(REG_UNMAPPED, THR_MAX);
    send_detect(16'sh7FFF, 16'sh8000);

    // Random settings, small constellations; every third phase runs without gaps
    for (int p = 0; p < 10; p++) begin
      set_config(pick_size(), pick_threshold());
      no_gaps = (p % 3 == 2);
      repeat (10) random_item();
      no_gaps = 1'b0;
    end

    wait_idle();
    repeat (12) @(posedge clk);
    sb.report_leftover();
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/nsd_pkg.sv
rtl/core/nsd_dist.sv
rtl/core/nearest_symbol_detector.sv
rtl/core/nsd_checker.sv
tb/tb_top.sv
